/* hdl/mvt_pkg.sv */
// ----------------------------------------------------------------------------
// mvt_pkg
// Shared constants and types for the 4x4 matrix by 4-vector transform unit.
// ----------------------------------------------------------------------------
package mvt_pkg;

    localparam int MATRIX_DIM     = 4;
    localparam int CFG_REGS       = 2 * MATRIX_DIM;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 64;
    localparam int FIELD_BITS     = 32;
    localparam int HALF_BITS      = CFG_DATA_BITS / 2;

    typedef logic [CFG_DATA_BITS-1:0] cfg_word_t;
    typedef logic [FIELD_BITS-1:0]    field_t;

    // identity matrix in the register layout, 1.0 in Q16.16 on the diagonal
    localparam cfg_word_t CFG_RESET [CFG_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage

/* hdl/mat4_vec4_transform_unit.sv */
// ----------------------------------------------------------------------------
// mat4_vec4_transform_unit
// Multiplies a signed fixed point 4-vector by a 4x4 matrix held in config
// registers, with exact row sums, arithmetic shift and saturation.
// Throughput: one beat per cycle unless out_stall backs up the full pipe;
// 16 parallel multipliers feed a 4-stage pipe.
// Reset: valid bits clear and the matrix returns to identity at once.
// ----------------------------------------------------------------------------
module mat4_vec4_transform_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_write_en,
    input  logic [mvt_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [mvt_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [mvt_pkg::FIELD_BITS-1:0] vector_x,
    input  logic signed [mvt_pkg::FIELD_BITS-1:0] vector_y,
    input  logic signed [mvt_pkg::FIELD_BITS-1:0] vector_z,
    input  logic signed [mvt_pkg::FIELD_BITS-1:0] vector_w,

    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [mvt_pkg::FIELD_BITS-1:0] result_x,
    output logic signed [mvt_pkg::FIELD_BITS-1:0] result_y,
    output logic signed [mvt_pkg::FIELD_BITS-1:0] result_z,
    output logic signed [mvt_pkg::FIELD_BITS-1:0] result_w,
    output logic                                 saturated
);

    localparam int DIM    = mvt_pkg::MATRIX_DIM;
    localparam int PROD_W = 2 * WORD_BITS;
    localparam int PAIR_W = PROD_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int FB     = mvt_pkg::FIELD_BITS;

    localparam logic signed [WORD_BITS-1:0] SAT_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] SAT_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam logic signed [FB-1:0] SAT_MAX_EXT = FB'(SAT_MAX);
    localparam logic signed [FB-1:0] SAT_MIN_EXT = FB'(SAT_MIN);

    // matrix registers
    mvt_pkg::cfg_word_t mat_reg [mvt_pkg::CFG_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mvt_pkg::CFG_REGS; i++)
            begin
                mat_reg[i] <= mvt_pkg::CFG_RESET[i];
            end
        end
        else if (cfg_write_en)
        begin
            mat_reg[cfg_index] <= cfg_data;
        end
    end

    // pipeline valid bits and per-stage ready
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic rdy1, rdy2, rdy3, rdy4;

    assign rdy4     = !v4_reg || !out_stall;
    assign rdy3     = !v3_reg || rdy4;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_stall = !rdy1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdy3)
            begin
                v3_reg <= v2_reg;
            end
            if (rdy4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // stage 1: sixteen products
    logic signed [PROD_W-1:0] vec_ext [DIM];
    logic signed [PROD_W-1:0] prod_next [DIM][DIM];
    logic signed [PROD_W-1:0] prod_reg  [DIM][DIM];

    always_comb
    begin
        logic signed [WORD_BITS-1:0] ent;
        vec_ext[0] = PROD_W'($signed(vector_x[WORD_BITS-1:0]));
        vec_ext[1] = PROD_W'($signed(vector_y[WORD_BITS-1:0]));
        vec_ext[2] = PROD_W'($signed(vector_z[WORD_BITS-1:0]));
        vec_ext[3] = PROD_W'($signed(vector_w[WORD_BITS-1:0]));
        for (int r = 0; r < DIM; r++)
        begin
            for (int c = 0; c < DIM; c++)
            begin
                ent = $signed(mat_reg[2*r + c/2][(c%2)*mvt_pkg::HALF_BITS +: WORD_BITS]);
                prod_next[r][c] = PROD_W'(ent) * vec_ext[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            prod_reg <= prod_next;
        end
    end

    // stage 2: pair sums, stage 3: row sums
    logic signed [PAIR_W-1:0] pair_reg [DIM][2];
    logic signed [SUM_W-1:0]  sum_reg  [DIM];

    always_ff @(posedge clk)
    begin
        if (rdy2 && v1_reg)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                pair_reg[r][0] <= PAIR_W'(prod_reg[r][0]) + PAIR_W'(prod_reg[r][1]);
                pair_reg[r][1] <= PAIR_W'(prod_reg[r][2]) + PAIR_W'(prod_reg[r][3]);
            end
        end
        if (rdy3 && v2_reg)
        begin
            for (int r = 0; r < DIM; r++)
            begin
                sum_reg[r] <= SUM_W'(pair_reg[r][0]) + SUM_W'(pair_reg[r][1]);
            end
        end
    end

    // stage 4: scale down, clip, output register
    logic signed [FB-1:0] res_next [DIM];
    logic signed [FB-1:0] res_reg  [DIM];
    logic                 sat_next;
    logic                 sat_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] shifted;
        logic [SUM_W-WORD_BITS:0] top;
        sat_next = 1'b0;
        for (int r = 0; r < DIM; r++)
        begin
            shifted = sum_reg[r] >>> FRAC_BITS;
            top     = shifted[SUM_W-1:WORD_BITS-1];
            if ((&top) || !(|top))
            begin
                res_next[r] = FB'($signed(shifted[WORD_BITS-1:0]));
            end
            else
            begin
                sat_next    = 1'b1;
                res_next[r] = shifted[SUM_W-1] ? SAT_MIN_EXT : SAT_MAX_EXT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy4 && v3_reg)
        begin
            res_reg <= res_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = v4_reg;
    assign result_x  = res_reg[0];
    assign result_y  = res_reg[1];
    assign result_z  = res_reg[2];
    assign result_w  = res_reg[3];
    assign saturated = sat_reg;

`ifndef SYNTHESIS
    // input is held back only when every stage is full and the output stalls
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && v4_reg && out_stall))
        else $error("input stalled with a bubble in the pipe");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted beat did not enter stage 1");

    a_mid_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && rdy3) |=> v3_reg)
        else $error("beat lost between stage 2 and stage 3");

    a_sat_clips: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (result_x == SAT_MAX_EXT || result_x == SAT_MIN_EXT ||
             result_y == SAT_MAX_EXT || result_y == SAT_MIN_EXT ||
             result_z == SAT_MAX_EXT || result_z == SAT_MIN_EXT ||
             result_w == SAT_MAX_EXT || result_w == SAT_MIN_EXT))
        else $error("saturated flag without a clipped component");
`endif

endmodule
